### hw/rtl/int_queue_with_insert_remove_stats_defines.svh
// ----------------------------------------------------------------------------
// Integer queue assertion macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef INT_QUEUE_WITH_INSERT_REMOVE_STATS_DEFINES_SVH
`define INT_QUEUE_WITH_INSERT_REMOVE_STATS_DEFINES_SVH

// same-cycle implication
`define IQIRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IQIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define IQIRS_ASSERT_ALWAYS(lbl, clk, rst_n, cons, msg) \
    `IQIRS_ASSERT_IMPL(lbl, clk, rst_n, 1'b1, cons, msg)

`endif

### hw/rtl/iqirs_pkg.sv
// ----------------------------------------------------------------------------
// Integer queue package
// Request and status codes, sequencer states and stream beat widths.
// ----------------------------------------------------------------------------
package iqirs_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 184;
    localparam int TUSER_W   = 3;
    localparam int POS_W     = 6;
    localparam int ENTRY_W   = 6;
    localparam int WORD_W    = 32;
    localparam int TOTAL_W   = 37;
    localparam int MEAN_W    = 40;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DROP   = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_STATS  = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EMPTY    = 3'd1;
    localparam logic [2:0] STS_BADPOS   = 3'd2;
    localparam logic [2:0] STS_NOTFOUND = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_SCAN,
        ST_STAT,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

### hw/rtl/int_queue_with_insert_remove_stats.sv
// ----------------------------------------------------------------------------
// Integer queue with positional insert, remove by value and statistics
// Throughput: one request at a time, set by the entry memory with one read and one
//   write port (one entry per cycle) and the one-bit-per-cycle restoring divider.
// Reset: synchronous active low; queue empty, no beat pending, memory untouched.
// ----------------------------------------------------------------------------
`include "int_queue_with_insert_remove_stats_defines.svh"

module int_queue_with_insert_remove_stats #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value[31:0], position[37:32], zero pad
    input  logic [iqirs_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // action[2:0]
    input  logic [iqirs_pkg::TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // removed_value[31:0], min_value[63:32], max_value[95:64], total[132:96],
    // mean_fixed[172:133], entries[178:173], zero pad
    output logic [iqirs_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [iqirs_pkg::TUSER_W-1:0]   o_m_axis_tuser
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = DATA_WIDTH + CW;
    localparam int NW  = SW + 8;
    localparam int DCW = $clog2(NW);

    // entry memory
    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rdata;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;

    // control
    iqirs_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_pidx, n_pidx;
    logic              r_pv, n_pv;
    logic              r_m_valid, n_m_valid;
    logic [DCW-1:0]    r_dcnt, n_dcnt;

    // payload
    logic signed [DATA_WIDTH-1:0] r_val, n_val;
    logic signed [DATA_WIDTH-1:0] r_removed, n_removed;
    logic signed [DATA_WIDTH-1:0] r_min, n_min;
    logic signed [DATA_WIDTH-1:0] r_max, n_max;
    logic signed [SW-1:0]         r_sum, n_sum;
    logic [NW-1:0]                r_q, n_q;
    logic [CW-1:0]                r_rem, n_rem;
    logic                         r_neg, n_neg;
    logic                         r_stat_ok, n_stat_ok;
    logic [2:0]                   r_status, n_status;
    logic [iqirs_pkg::M_TDATA_W-1:0] r_m_data, n_m_data;
    logic [iqirs_pkg::TUSER_W-1:0]   r_m_user, n_m_user;

    logic                         s_acc;
    logic                         out_free;
    logic [2:0]                   in_act;
    logic signed [DATA_WIDTH-1:0] in_val;
    logic [iqirs_pkg::POS_W-1:0]  in_pos;
    logic                         pos_bad;
    logic                         is_full;
    logic                         is_empty;
    logic                         fwd_more;
    logic                         fwd_done;
    logic                         up_more;
    logic                         hit;
    logic                         div_last;
    logic [CW:0]                  div_sh;
    logic                         div_ge;
    logic [CW:0]                  div_sub;
    logic [NW-1:0]                div_num;
    logic signed [NW:0]           mean_s;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign in_act   = i_s_axis_tuser;
    assign in_val   = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign in_pos   = i_s_axis_tdata[iqirs_pkg::WORD_W +: iqirs_pkg::POS_W];
    assign pos_bad  = (in_pos == '0) || (32'(in_pos) > 32'(r_count));
    assign is_full  = r_count >= CW'(DEPTH);
    assign is_empty = r_count == '0;
    assign fwd_more = r_idx < r_count;
    assign fwd_done = !fwd_more && !r_pv;
    assign up_more  = r_idx > r_k;
    assign hit      = r_pv && (r_rdata == r_val);
    assign div_last = r_dcnt == DCW'(NW - 1);
    assign div_sh   = {r_rem, r_q[NW-1]};
    assign div_ge   = div_sh >= {1'b0, r_count};
    assign div_sub  = div_sh - {1'b0, r_count};
    assign div_num  = {r_sum, 8'd0};

    assign o_s_axis_tready = (r_state == iqirs_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    always_comb begin
        if (r_neg) begin
            mean_s = -$signed({1'b0, r_q});
        end else begin
            mean_s = $signed({1'b0, r_q});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iqirs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (in_act)
                        iqirs_pkg::ACT_INSERT: begin
                            if (!pos_bad && !is_full) begin
                                n_state = iqirs_pkg::ST_SHIFT_UP;
                            end else begin
                                n_state = iqirs_pkg::ST_OUT;
                            end
                        end
                        iqirs_pkg::ACT_DROP:
                            n_state = is_empty ? iqirs_pkg::ST_OUT : iqirs_pkg::ST_SHIFT_DN;
                        iqirs_pkg::ACT_REMOVE:
                            n_state = is_empty ? iqirs_pkg::ST_OUT : iqirs_pkg::ST_SCAN;
                        iqirs_pkg::ACT_STATS:
                            n_state = is_empty ? iqirs_pkg::ST_OUT : iqirs_pkg::ST_STAT;
                        default:
                            n_state = iqirs_pkg::ST_OUT;
                    endcase
                end
            end
            iqirs_pkg::ST_SHIFT_UP: begin
                if (!up_more && !r_pv) begin
                    n_state = iqirs_pkg::ST_OUT;
                end
            end
            iqirs_pkg::ST_SHIFT_DN: begin
                if (fwd_done) begin
                    n_state = iqirs_pkg::ST_OUT;
                end
            end
            iqirs_pkg::ST_SCAN: begin
                priority if (hit) begin
                    n_state = iqirs_pkg::ST_SHIFT_DN;
                end else if (fwd_done) begin
                    n_state = iqirs_pkg::ST_OUT;
                end else begin
                    n_state = iqirs_pkg::ST_SCAN;
                end
            end
            iqirs_pkg::ST_STAT: begin
                if (fwd_done) begin
                    n_state = iqirs_pkg::ST_DIV;
                end
            end
            iqirs_pkg::ST_DIV: begin
                if (div_last) begin
                    n_state = iqirs_pkg::ST_OUT;
                end
            end
            iqirs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = iqirs_pkg::ST_IDLE;
                end
            end
            default: n_state = iqirs_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_k       = r_k;
        n_pidx    = r_pidx;
        n_pv      = r_pv;
        n_dcnt    = r_dcnt;
        n_val     = r_val;
        n_removed = r_removed;
        n_min     = r_min;
        n_max     = r_max;
        n_sum     = r_sum;
        n_q       = r_q;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_stat_ok = r_stat_ok;
        n_status  = r_status;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = r_val;
        mem_raddr = r_idx[AW-1:0];

        unique case (r_state)
            iqirs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_val     = in_val;
                    n_status  = iqirs_pkg::STS_OK;
                    n_removed = '0;
                    n_stat_ok = 1'b0;
                    n_pv      = 1'b0;
                    n_idx     = '0;
                    n_min     = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
                    n_max     = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
                    n_sum     = '0;
                    unique case (in_act)
                        iqirs_pkg::ACT_APPEND: begin
                            if (is_full) begin
                                n_status = iqirs_pkg::STS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = in_val;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        iqirs_pkg::ACT_INSERT: begin
                            priority if (pos_bad) begin
                                n_status = iqirs_pkg::STS_BADPOS;
                            end else if (is_full) begin
                                n_status = iqirs_pkg::STS_FULL;
                            end else begin
                                n_k   = CW'(in_pos - iqirs_pkg::POS_W'(1));
                                n_idx = r_count;
                            end
                        end
                        iqirs_pkg::ACT_DROP,
                        iqirs_pkg::ACT_REMOVE,
                        iqirs_pkg::ACT_STATS: begin
                            if (is_empty) begin
                                n_status = iqirs_pkg::STS_EMPTY;
                            end
                        end
                        iqirs_pkg::ACT_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            iqirs_pkg::ST_SHIFT_UP: begin
                mem_raddr = AW'(r_idx - CW'(1));
                if (up_more) begin
                    n_idx  = r_idx - CW'(1);
                    n_pidx = AW'(r_idx - CW'(1));
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx + AW'(1);
                    mem_wdata = r_rdata;
                end else if (!up_more) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k[AW-1:0];
                    mem_wdata = r_val;
                    n_count   = r_count + CW'(1);
                end
            end
            iqirs_pkg::ST_SHIFT_DN: begin
                if (fwd_more) begin
                    n_idx  = r_idx + CW'(1);
                    n_pidx = r_idx[AW-1:0];
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_pidx == '0) begin
                        n_removed = r_rdata;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pidx - AW'(1);
                        mem_wdata = r_rdata;
                    end
                end
                if (fwd_done) begin
                    n_count = r_count - CW'(1);
                end
            end
            iqirs_pkg::ST_SCAN: begin
                priority if (hit) begin
                    n_idx = CW'(r_pidx) + CW'(1);
                    n_pv  = 1'b0;
                end else if (fwd_more) begin
                    n_idx  = r_idx + CW'(1);
                    n_pidx = r_idx[AW-1:0];
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (fwd_done) begin
                        n_status = iqirs_pkg::STS_NOTFOUND;
                    end
                end
            end
            iqirs_pkg::ST_STAT: begin
                if (fwd_more) begin
                    n_idx  = r_idx + CW'(1);
                    n_pidx = r_idx[AW-1:0];
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_rdata < r_min) begin
                        n_min = r_rdata;
                    end
                    if (r_rdata > r_max) begin
                        n_max = r_rdata;
                    end
                    n_sum = r_sum + SW'(r_rdata);
                end
                if (fwd_done) begin
                    n_neg     = r_sum[SW-1];
                    n_q       = r_sum[SW-1] ? (~div_num + NW'(1)) : div_num;
                    n_rem     = '0;
                    n_dcnt    = '0;
                    n_stat_ok = 1'b1;
                end
            end
            iqirs_pkg::ST_DIV: begin
                n_dcnt = r_dcnt + DCW'(1);
                if (div_ge) begin
                    n_rem = div_sub[CW-1:0];
                    n_q   = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_rem = div_sh[CW-1:0];
                    n_q   = {r_q[NW-2:0], 1'b0};
                end
            end
            iqirs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_status;
                    n_m_data  = {
                        5'd0,
                        iqirs_pkg::ENTRY_W'(r_count),
                        r_stat_ok ? iqirs_pkg::MEAN_W'(mean_s) : iqirs_pkg::MEAN_W'(0),
                        r_stat_ok ? iqirs_pkg::TOTAL_W'(r_sum) : iqirs_pkg::TOTAL_W'(0),
                        r_stat_ok ? iqirs_pkg::WORD_W'(r_max) : iqirs_pkg::WORD_W'(0),
                        r_stat_ok ? iqirs_pkg::WORD_W'(r_min) : iqirs_pkg::WORD_W'(0),
                        iqirs_pkg::WORD_W'(r_removed)
                    };
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= iqirs_pkg::ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_k       <= '0;
            r_pidx    <= '0;
            r_pv      <= 1'b0;
            r_m_valid <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_k       <= n_k;
            r_pidx    <= n_pidx;
            r_pv      <= n_pv;
            r_m_valid <= n_m_valid;
            r_dcnt    <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_removed <= n_removed;
        r_min     <= n_min;
        r_max     <= n_max;
        r_sum     <= n_sum;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_stat_ok <= n_stat_ok;
        r_status  <= n_status;
        r_m_data  <= n_m_data;
        r_m_user  <= n_m_user;
    end

    `IQIRS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "fill count above depth")
    `IQIRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_acc, r_state != iqirs_pkg::ST_IDLE, "accepted beat left sequencer idle")
    `IQIRS_ASSERT_IMPL(a_write_in_range, i_clk, i_rst_n, mem_we, CW'(mem_waddr) <= r_count, "write beyond fill count")
    `IQIRS_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == iqirs_pkg::ST_DIV, r_count != '0, "divide by empty count")

endmodule

### tb/tb_int_queue_with_insert_remove_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the integer queue with insert, remove and statistics
// Streams append, insert, drop, remove, stats and clear requests into the
// queue, with random gaps on both sides. It predicts every result beat from
// its own model of the queue and checks every field of each result.
// ----------------------------------------------------------------------------
module tb_int_queue_with_insert_remove_stats;

    localparam int QDEPTH = 32;
    localparam int QWIDTH = 32;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] value;
        logic [5:0]  position;
        bit          hold;      // wait for all results before this beat
    } t_queue_req;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] removed;
        logic [31:0] min_v;
        logic [31:0] max_v;
        logic [36:0] total;
        logic [39:0] mean;
        logic [5:0]  entries;
    } t_queue_resp;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [iqirs_pkg::S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [iqirs_pkg::TUSER_W-1:0]   i_s_axis_tuser = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [iqirs_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic [iqirs_pkg::TUSER_W-1:0]   o_m_axis_tuser;

    int_queue_with_insert_remove_stats #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (QWIDTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_queue_req  req_q[$];
    t_queue_resp rsp_q[$];
    int          entry_q[$];

    int     beats_in = 0;
    int     beats_issued = 0;
    int     results_seen = 0;
    int     err_count = 0;
    int     src_gap = 0;
    int     sink_stall = 0;
    bit     calm = 1'b0;
    int     cycle_cnt = 0;
    int     n_full = 0;
    int     n_badpos = 0;
    int     n_notfound = 0;
    int     n_empty = 0;
    int     n_ok = 0;

    // generator-side estimate of the fill level
    int     est_fill = 0;
    int     gen_count = 0;
    int     recent_vals[8] = '{default: 0};

    function automatic t_queue_resp apply_request(input t_queue_req r);
        t_queue_resp rsp;
        int          v;
        int          n;
        int          idx;
        longint      acc;
        longint      lo;
        longint      hi;
        longint      avg;
        rsp = '{default: '0};
        rsp.status = iqirs_pkg::STS_OK;
        v = r.value;
        n = entry_q.size();
        case (r.action)
            iqirs_pkg::ACT_APPEND: begin
                if (n >= QDEPTH) rsp.status = iqirs_pkg::STS_FULL;
                else entry_q.push_back(v);
            end
            iqirs_pkg::ACT_INSERT: begin
                if (int'(r.position) < 1 || int'(r.position) > n)
                    rsp.status = iqirs_pkg::STS_BADPOS;
                else if (n >= QDEPTH)
                    rsp.status = iqirs_pkg::STS_FULL;
                else
                    entry_q.insert(int'(r.position) - 1, v);
            end
            iqirs_pkg::ACT_DROP: begin
                if (n == 0) rsp.status = iqirs_pkg::STS_EMPTY;
                else rsp.removed = entry_q.pop_front();
            end
            iqirs_pkg::ACT_REMOVE: begin
                if (n == 0) begin
                    rsp.status = iqirs_pkg::STS_EMPTY;
                end else begin
                    idx = -1;
                    for (int i = 0; i < n; i++)
                        if (idx < 0 && entry_q[i] == v) idx = i;
                    if (idx < 0) rsp.status = iqirs_pkg::STS_NOTFOUND;
                    else entry_q.delete(idx);
                end
            end
            iqirs_pkg::ACT_STATS: begin
                if (n == 0) begin
                    rsp.status = iqirs_pkg::STS_EMPTY;
                end else begin
                    lo = entry_q[0];
                    hi = entry_q[0];
                    acc = 0;
                    foreach (entry_q[i]) begin
                        if (entry_q[i] < lo) lo = entry_q[i];
                        if (entry_q[i] > hi) hi = entry_q[i];
                        acc += entry_q[i];
                    end
                    avg = (acc * 256) / longint'(n);
                    rsp.min_v = lo[31:0];
                    rsp.max_v = hi[31:0];
                    rsp.total = acc[36:0];
                    rsp.mean  = avg[39:0];
                end
            end
            iqirs_pkg::ACT_CLEAR: begin
                entry_q.delete();
            end
            default: ;
        endcase
        rsp.entries = 6'(entry_q.size());
        return rsp;
    endfunction

    function automatic bit idle_ok();
        return !calm && (req_q.size() > 150);
    endfunction

    task automatic check_field(input string tag, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (err_count < 10)
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         tag, results_seen, want, got);
            err_count++;
        end
    endtask

    // --- stimulus helpers --------------------------------------------------
    task automatic push_req(input logic [2:0] act, input logic [31:0] val,
                            input logic [5:0] pos, input bit hold);
        t_queue_req r;
        r.action = act;
        r.value = val;
        r.position = pos;
        r.hold = hold;
        req_q.push_back(r);
        gen_count++;
        case (act)
            iqirs_pkg::ACT_APPEND: begin
                if (est_fill < QDEPTH) est_fill++;
                recent_vals[$urandom_range(0, 7)] = val;
            end
            iqirs_pkg::ACT_INSERT: begin
                if (pos >= 1 && int'(pos) <= est_fill && est_fill < QDEPTH) est_fill++;
                recent_vals[$urandom_range(0, 7)] = val;
            end
            iqirs_pkg::ACT_DROP, iqirs_pkg::ACT_REMOVE: if (est_fill > 0) est_fill--;
            iqirs_pkg::ACT_CLEAR: est_fill = 0;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 16)) - 8);
            3, 4: return recent_vals[$urandom_range(0, 7)];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_pos();
        if (est_fill == 0) return 6'd1;
        return 6'($urandom_range(1, est_fill));
    endfunction

    // --- source driver -----------------------------------------------------
    always @(negedge i_clk) begin
        t_queue_req nxt;
        bit         free_slot;
        if (i_rst_n) begin
            free_slot = !i_s_axis_tvalid || (beats_in == beats_issued);
            if (free_slot) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (req_q.size() != 0 && !(req_q[0].hold && rsp_q.size() != 0)) begin
                    nxt = req_q.pop_front();
                    i_s_axis_tdata  <= {2'b00, nxt.position, nxt.value};
                    i_s_axis_tuser  <= nxt.action;
                    i_s_axis_tvalid <= 1'b1;
                    beats_issued++;
                    if (idle_ok() && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 6);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // --- sink backpressure -------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_ok() && $urandom_range(0, 4) == 0) begin
            sink_stall = $urandom_range(0, 5);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // --- monitor: predict on accepted requests, check result beats -------
    always @(posedge i_clk) begin
        t_queue_req  req;
        t_queue_resp want;
        cycle_cnt++;
        if (cycle_cnt % 256 == 0) calm = ($urandom_range(0, 3) == 0);
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (rsp_q.size() == 0) begin
                    if (err_count < 10)
                        $display("result beat with nothing expected: status %h data %h",
                                 o_m_axis_tuser, o_m_axis_tdata);
                    err_count++;
                end else begin
                    want = rsp_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_m_axis_tuser));
                    check_field("removed_value", 64'(want.removed), 64'(o_m_axis_tdata[31:0]));
                    check_field("min_value", 64'(want.min_v), 64'(o_m_axis_tdata[63:32]));
                    check_field("max_value", 64'(want.max_v), 64'(o_m_axis_tdata[95:64]));
                    check_field("total", 64'(want.total), 64'(o_m_axis_tdata[132:96]));
                    check_field("mean_fixed", 64'(want.mean), 64'(o_m_axis_tdata[172:133]));
                    check_field("entries", 64'(want.entries), 64'(o_m_axis_tdata[178:173]));
                    case (want.status)
                        iqirs_pkg::STS_OK:       n_ok++;
                        iqirs_pkg::STS_EMPTY:    n_empty++;
                        iqirs_pkg::STS_BADPOS:   n_badpos++;
                        iqirs_pkg::STS_NOTFOUND: n_notfound++;
                        iqirs_pkg::STS_FULL:     n_full++;
                        default: ;
                    endcase
                end
                results_seen++;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                req.action   = i_s_axis_tuser;
                req.value    = i_s_axis_tdata[31:0];
                req.position = i_s_axis_tdata[37:32];
                req.hold     = 1'b0;
                rsp_q.push_back(apply_request(req));
                beats_in++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_int_queue_with_insert_remove_stats: errors");
        $finish;
    end

    initial begin
        int          n;
        int          k;
        int          guard;
        logic [31:0] fill_v;
        logic [5:0]  pos;

        // directed part
        push_req(iqirs_pkg::ACT_STATS,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_DROP,   32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_REMOVE, 32'h1,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h11,        6'd1,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h11,        6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_APPEND, 32'h7fff_ffff, 6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_APPEND, 32'h8000_0000, 6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_APPEND, 32'hffff_ffff, 6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_STATS,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h5,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h5,         6'd1,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h0,         6'd4,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h9,         6'd6,  1'b0);
        push_req(iqirs_pkg::ACT_INSERT, 32'h9,         6'd63, 1'b0);
        push_req(iqirs_pkg::ACT_STATS,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_REMOVE, 32'hffff_ffff, 6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_REMOVE, 32'd12345,     6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_DROP,   32'h0,         6'd0,  1'b0);
        push_req(ACT_SPARE6,            32'hffff_ffff, 6'd63, 1'b0);
        push_req(ACT_SPARE7,            32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_STATS,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_CLEAR,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_CLEAR,  32'h0,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_APPEND, 32'h1,         6'd0,  1'b0);
        push_req(iqirs_pkg::ACT_STATS,  32'h0,         6'd0,  1'b1);

        // random part, built from segments of different flavors
        while (gen_count < 1025) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    n = $urandom_range(10, 30);
                    repeat (n) begin
                        k = $urandom_range(0, 9);
                        if (k < 5)
                            push_req(iqirs_pkg::ACT_APPEND, rand_value(),
                                     6'($urandom_range(0, 63)), 1'b0);
                        else if (k < 8)
                            push_req(iqirs_pkg::ACT_INSERT, rand_value(), pick_pos(), 1'b0);
                        else if (k == 8)
                            push_req(iqirs_pkg::ACT_STATS, $urandom,
                                     6'($urandom_range(0, 63)), 1'b0);
                        else
                            push_req(iqirs_pkg::ACT_REMOVE, recent_vals[$urandom_range(0, 7)],
                                     6'($urandom_range(0, 63)), 1'b0);
                    end
                end
                4, 5: begin
                    n = $urandom_range(5, 25);
                    repeat (n) begin
                        k = $urandom_range(0, 9);
                        if (k < 5)
                            push_req(iqirs_pkg::ACT_DROP, $urandom,
                                     6'($urandom_range(0, 63)), 1'b0);
                        else if (k < 8)
                            push_req(iqirs_pkg::ACT_REMOVE, rand_value(),
                                     6'($urandom_range(0, 63)), 1'b0);
                        else
                            push_req(iqirs_pkg::ACT_STATS, $urandom,
                                     6'($urandom_range(0, 63)), 1'b0);
                    end
                end
                6: begin
                    // fill to the brim, then hit the full checks
                    case ($urandom_range(0, 2))
                        0: fill_v = 32'h7fff_ffff;
                        1: fill_v = 32'h8000_0000;
                        default: fill_v = rand_value();
                    endcase
                    push_req(iqirs_pkg::ACT_CLEAR, $urandom, 6'($urandom_range(0, 63)), 1'b0);
                    guard = 0;
                    while (est_fill < QDEPTH && guard < 64) begin
                        if (est_fill > 0 && $urandom_range(0, 3) == 0)
                            push_req(iqirs_pkg::ACT_INSERT, fill_v, pick_pos(), 1'b0);
                        else
                            push_req(iqirs_pkg::ACT_APPEND, fill_v,
                                     6'($urandom_range(0, 63)), 1'b0);
                        guard++;
                    end
                    push_req(iqirs_pkg::ACT_STATS, $urandom, 6'($urandom_range(0, 63)), 1'b0);
                    push_req(iqirs_pkg::ACT_APPEND, rand_value(),
                             6'($urandom_range(0, 63)), 1'b0);
                    push_req(iqirs_pkg::ACT_INSERT, rand_value(), pick_pos(), 1'b0);
                    push_req(iqirs_pkg::ACT_INSERT, rand_value(), 6'd0, 1'b0);
                    push_req(iqirs_pkg::ACT_INSERT, rand_value(), 6'd33, 1'b0);
                    push_req(iqirs_pkg::ACT_DROP, $urandom, 6'($urandom_range(0, 63)), 1'b0);
                    push_req(iqirs_pkg::ACT_STATS, $urandom, 6'($urandom_range(0, 63)), 1'b0);
                end
                7: begin
                    n = $urandom_range(5, 15);
                    repeat (n)
                        push_req(3'($urandom_range(0, 7)), $urandom,
                                 6'($urandom_range(0, 63)), 1'b0);
                end
                8: begin
                    n = $urandom_range(10, 25);
                    repeat (n) begin
                        case ($urandom_range(0, 4))
                            0: pos = 6'd0;
                            1: pos = 6'(est_fill);
                            2: pos = 6'(est_fill + 1);
                            3: pos = 6'd63;
                            default: pos = pick_pos();
                        endcase
                        push_req(3'($urandom_range(0, 5)), rand_value(), pos, 1'b0);
                    end
                end
                default: begin
                    push_req(iqirs_pkg::ACT_STATS, $urandom, 6'($urandom_range(0, 63)), 1'b1);
                end
            endcase
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || beats_in != beats_issued) @(posedge i_clk);
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("run covered %0d requests and %0d result beats in %0d cycles",
                 beats_in, results_seen, cycle_cnt);
        $display("statuses seen: ok %0d, empty %0d, bad position %0d, not found %0d, full %0d",
                 n_ok, n_empty, n_badpos, n_notfound, n_full);
        if (err_count == 0 && rsp_q.size() == 0) begin
            $display("tb_int_queue_with_insert_remove_stats: clean");
        end else begin
            $display("tb_int_queue_with_insert_remove_stats: errors");
        end
        $finish;
    end

endmodule
